>>> sv/msbr_pkg.sv
// ----------------------------------------------------------------------------
// msbr_pkg
// Shared constants, item codes and step unit types of the MSB-first bit
// reader.
// ----------------------------------------------------------------------------
package msbr_pkg;

   localparam int BUF_DEPTH     = 4096;
   localparam int MAX_READ_BITS = 32;
   localparam int BYTE_BITS     = 8;
   localparam int ADDR_W        = $clog2(BUF_DEPTH);

   localparam int FUNC_W   = 3;
   localparam int CNT_W    = 6;
   localparam int POS_W    = 13;
   localparam int BL_W     = 4;
   localparam int SUB_W    = 3;
   localparam int BITPOS_W = POS_W + SUB_W;
   localparam int DEPTH_W  = 17;
   localparam int VAL_W    = 32;
   localparam int OVR_W    = 20;

   localparam logic [OVR_W-1:0] COUNT_MAX = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 3'd0,
      FUNC_READ   = 3'd1,
      FUNC_UNPAD  = 3'd2,
      FUNC_SETPOS = 3'd3,
      FUNC_REWIND = 3'd4
   } msbr_func_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] byte_data;
      logic [BL_W-1:0]      bits_left;
      logic [CNT_W-1:0]     need;
      logic [VAL_W-1:0]     acc;
   } msbr_step_in_type;

   typedef struct packed {
      logic                 take_all;
      logic [CNT_W-1:0]     need;
      logic [BL_W-1:0]      bits_left;
      logic [VAL_W-1:0]     acc;
   } msbr_step_out_type;

endpackage

>>> sv/msbr_ram.sv
// ----------------------------------------------------------------------------
// msbr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module msbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/msbr_step_unit.sv
// ----------------------------------------------------------------------------
// msbr_step_unit
// Shared extract-and-shift unit: takes the unread bits of one buffer byte
// and merges them into the read accumulator at the right place.
// ----------------------------------------------------------------------------
module msbr_step_unit import msbr_pkg::*; (
   input  msbr_step_in_type  step_in,
   output msbr_step_out_type step_out
);

   logic [BYTE_BITS-1:0]       mask;
   logic [BYTE_BITS-1:0]       bits;
   logic                       take_all;
   logic [CNT_W-1:0]           need_rem;
   logic [BL_W-1:0]            part_left;
   logic [VAL_W+BYTE_BITS-1:0] wide;
   logic [BYTE_BITS-1:0]       tail;

   assign mask      = {BYTE_BITS{1'b1}} >> (BL_W'(BYTE_BITS) - step_in.bits_left);
   assign bits      = step_in.byte_data & mask;
   assign take_all  = step_in.need >= CNT_W'(step_in.bits_left);
   assign need_rem  = step_in.need - CNT_W'(step_in.bits_left);
   // whole remainder of the byte lands above the bits still to come
   assign wide      = {{VAL_W{1'b0}}, bits} << need_rem;
   // partial byte: keep the top bits only
   assign part_left = step_in.bits_left - step_in.need[BL_W-1:0];
   assign tail      = bits >> part_left;

   always_comb begin
      step_out.take_all = take_all;
      if (take_all) begin
         step_out.need      = need_rem;
         step_out.bits_left = BL_W'(BYTE_BITS);
         step_out.acc       = step_in.acc | wide[VAL_W-1:0];
      end else begin
         step_out.need      = '0;
         step_out.bits_left = part_left;
         step_out.acc       = step_in.acc | VAL_W'(tail);
      end
   end

endmodule

>>> sv/msb_first_bit_reader.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// MSB-first bit reader over a byte buffer loaded through the request channel.
// ----------------------------------------------------------------------------
// One word is handled at a time. Load, set position, rewind, unknown codes, a
// zero-bit read, unpad when aligned or at the end, and any read at the end
// pass through one execute state and one done state: req_ready rises again
// when the done state is left and the response is offered at that same edge.
// A read or unpad that touches k buffer bytes (k is at most 5 for a 32-bit
// read) passes, for each byte, through a buffer fetch state and a step state
// in the shared extract unit, between execute and done. A new word is taken
// while the previous response still waits; its response is held until the
// output is free, which stalls the input for as long as the response before
// it is not taken.
// The buffer holds no reset value: reading a byte that was never loaded
// returns unspecified bits.
// ----------------------------------------------------------------------------
module msb_first_bit_reader import msbr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [CNT_W-1:0]     req_bit_count,
   input  logic [POS_W-1:0]     req_byte_pos,
   input  logic [BL_W-1:0]      req_bit_pos,
   input  logic [BYTE_BITS-1:0] req_load_data,
   input  logic                 req_fill_bit,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VAL_W-1:0]     rsp_value,
   output logic                 rsp_at_end,
   output logic [OVR_W-1:0]     rsp_overrun_bits,
   output logic [POS_W-1:0]     rsp_byte_index,
   output logic [BL_W-1:0]      rsp_bits_left,
   input  logic                 csr_wr_en,
   input  logic [POS_W-1:0]     csr_wr_data
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_FETCH = 5'b00100,
      S_STEP  = 5'b01000,
      S_DONE  = 5'b10000
   } msbr_state_type;

   msbr_state_type state_ff, state_in;

   logic [POS_W-1:0]     len_cfg_ff;
   msbr_func_type        func_ff, func_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [POS_W-1:0]     pbyte_ff, pbyte_in;
   logic [BL_W-1:0]      pbit_ff, pbit_in;
   logic [BYTE_BITS-1:0] data_ff, data_in;
   logic                 fill_ff, fill_in;

   logic [POS_W-1:0]     cur_ff, cur_in;
   logic [BL_W-1:0]      bl_ff, bl_in;
   logic                 end_ff, end_in;
   logic [OVR_W-1:0]     ovr_ff, ovr_in;
   logic [CNT_W-1:0]     need_ff, need_in;
   logic [VAL_W-1:0]     acc_ff, acc_in;
   logic [VAL_W-1:0]     val_ff, val_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                 rsp_end_ff, rsp_end_in;
   logic [OVR_W-1:0]     rsp_ovr_ff, rsp_ovr_in;
   logic [POS_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic [BL_W-1:0]      rsp_bl_ff, rsp_bl_in;

   logic [POS_W-1:0]     eff_len;
   logic [CNT_W-1:0]     read_n;
   logic [OVR_W:0]       ovr_sum;
   logic [OVR_W-1:0]     ovr_sat;
   logic [BL_W-1:0]      pbit_eff;
   logic [SUB_W-1:0]     sp_low;
   logic                 rw_gt;
   logic [CNT_W-1:0]     rw_n;
   logic [BITPOS_W-1:0]  rw_pos;
   logic [BITPOS_W-1:0]  rw_new;
   logic [POS_W-1:0]     cur_inc;
   logic [BL_W-1:0]      bl_m1;
   logic                 unpad_bit;

   logic                 ram_we;
   logic [BYTE_BITS-1:0] ram_rdata;

   msbr_step_in_type     step_in;
   msbr_step_out_type    step_out;

   msbr_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (BUF_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(pbyte_ff)),
      .wr_data (data_ff),
      .rd_addr (ADDR_W'(cur_ff)),
      .rd_data (ram_rdata)
   );

   assign step_in.byte_data = ram_rdata;
   assign step_in.bits_left = bl_ff;
   assign step_in.need      = need_ff;
   assign step_in.acc       = acc_ff;

   msbr_step_unit u_step (
      .step_in  (step_in),
      .step_out (step_out)
   );

   assign ram_we = (state_ff == S_EXEC) && (func_ff == FUNC_LOAD) &&
                   (DEPTH_W'(pbyte_ff) < DEPTH_W'(BUF_DEPTH));

   assign eff_len = (DEPTH_W'(len_cfg_ff) > DEPTH_W'(BUF_DEPTH)) ?
                    POS_W'(BUF_DEPTH) : len_cfg_ff;

   assign read_n  = (cnt_ff > CNT_W'(MAX_READ_BITS)) ? CNT_W'(MAX_READ_BITS) : cnt_ff;
   assign ovr_sum = {1'b0, ovr_ff} + (OVR_W+1)'(read_n);
   assign ovr_sat = ovr_sum[OVR_W] ? COUNT_MAX : ovr_sum[OVR_W-1:0];

   assign pbit_eff = ((pbit_ff == '0) || (pbit_ff > BL_W'(BYTE_BITS))) ?
                     BL_W'(BYTE_BITS) : pbit_ff;
   assign sp_low   = SUB_W'(BL_W'(BYTE_BITS) - pbit_eff);

   // at the end, rewind eats the overrun first
   assign rw_gt  = OVR_W'(cnt_ff) > ovr_ff;
   assign rw_n   = end_ff ? (cnt_ff - ovr_ff[CNT_W-1:0]) : cnt_ff;
   assign rw_pos = {cur_ff, SUB_W'(BL_W'(BYTE_BITS) - bl_ff)};
   assign rw_new = (BITPOS_W'(rw_n) > rw_pos) ? '0 : (rw_pos - BITPOS_W'(rw_n));

   assign cur_inc   = cur_ff + POS_W'(1);
   assign bl_m1     = bl_ff - BL_W'(1);
   assign unpad_bit = ram_rdata[bl_m1[SUB_W-1:0]];

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      cnt_in       = cnt_ff;
      pbyte_in     = pbyte_ff;
      pbit_in      = pbit_ff;
      data_in      = data_ff;
      fill_in      = fill_ff;
      cur_in       = cur_ff;
      bl_in        = bl_ff;
      end_in       = end_ff;
      ovr_in       = ovr_ff;
      need_in      = need_ff;
      acc_in       = acc_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovr_in   = rsp_ovr_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bl_in    = rsp_bl_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
               func_in  = msbr_func_type'(req_func);
               cnt_in   = req_bit_count;
               pbyte_in = req_byte_pos;
               pbit_in  = req_bit_pos;
               data_in  = req_load_data;
               fill_in  = req_fill_bit;
               // snap the position to the end when it lies at or beyond it
               if (end_ff || (cur_ff >= eff_len)) begin
                  end_in = 1'b1;
                  cur_in = eff_len;
                  bl_in  = BL_W'(BYTE_BITS);
               end
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            val_in   = '0;
            unique case (func_ff)
               FUNC_READ: begin
                  if (end_ff) begin
                     ovr_in = ovr_sat;
                  end else if (read_n != '0) begin
                     need_in  = read_n;
                     acc_in   = '0;
                     state_in = S_FETCH;
                  end
               end
               FUNC_UNPAD: begin
                  if ((bl_ff == BL_W'(BYTE_BITS)) || end_ff) begin
                     val_in = VAL_W'(fill_ff);
                  end else begin
                     // consume the rest of the byte, answer with its top bit
                     need_in  = CNT_W'(bl_ff);
                     acc_in   = '0;
                     state_in = S_FETCH;
                  end
               end
               FUNC_SETPOS: begin
                  if (pbyte_ff < eff_len) begin
                     end_in = 1'b0;
                     cur_in = pbyte_ff;
                     bl_in  = pbit_eff;
                     ovr_in = '0;
                  end else begin
                     end_in = 1'b1;
                     cur_in = eff_len;
                     bl_in  = BL_W'(BYTE_BITS);
                     ovr_in = OVR_W'({pbyte_ff - eff_len, sp_low});
                  end
               end
               FUNC_REWIND: begin
                  if (end_ff && !rw_gt) begin
                     ovr_in = ovr_ff - OVR_W'(cnt_ff);
                  end else begin
                     if (end_ff) begin
                        ovr_in = '0;
                        end_in = 1'b0;
                     end
                     cur_in = rw_new[BITPOS_W-1:SUB_W];
                     bl_in  = BL_W'(BYTE_BITS) - BL_W'(rw_new[SUB_W-1:0]);
                  end
               end
               default: begin
               end
            endcase
         end
         S_FETCH: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            acc_in  = step_out.acc;
            need_in = step_out.need;
            bl_in   = step_out.bits_left;
            val_in  = (func_ff == FUNC_UNPAD) ? VAL_W'(unpad_bit) : step_out.acc;
            if (step_out.take_all) begin
               cur_in = cur_inc;
               if (cur_inc >= eff_len) begin
                  // ran off the end: the missing bits become the overrun
                  end_in   = 1'b1;
                  ovr_in   = OVR_W'(step_out.need);
                  state_in = S_DONE;
               end else if (step_out.need == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_FETCH;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_value_in = val_ff;
               rsp_end_in   = end_ff;
               rsp_ovr_in   = ovr_ff;
               rsp_byte_in  = cur_ff;
               rsp_bl_in    = bl_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_cfg_ff   <= '0;
         cur_ff       <= '0;
         bl_ff        <= BL_W'(BYTE_BITS);
         end_ff       <= 1'b0;
         ovr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         bl_ff        <= bl_in;
         end_ff       <= end_in;
         ovr_ff       <= ovr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            len_cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      cnt_ff       <= cnt_in;
      pbyte_ff     <= pbyte_in;
      pbit_ff      <= pbit_in;
      data_ff      <= data_in;
      fill_ff      <= fill_in;
      need_ff      <= need_in;
      acc_ff       <= acc_in;
      val_ff       <= val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovr_ff   <= rsp_ovr_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_bl_ff    <= rsp_bl_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_at_end       = rsp_end_ff;
   assign rsp_overrun_bits = rsp_ovr_ff;
   assign rsp_byte_index   = rsp_byte_ff;
   assign rsp_bits_left    = rsp_bl_ff;

   a_bits_left_range: assert property (@(posedge clock) disable iff (reset)
      (bl_ff != '0) && (bl_ff <= BL_W'(BYTE_BITS)))
      else $error("bits left out of range");

   a_overrun_needs_end: assert property (@(posedge clock) disable iff (reset)
      (ovr_ff != '0) |-> end_ff)
      else $error("overrun count set without end flag");

   a_step_after_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> $past(state_ff == S_FETCH))
      else $error("extract step without a buffer fetch");

endmodule

>>> tb/msb_first_bit_reader_tb.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader_tb
// Self-checking bench for the MSB-first bit reader. A scoreboard keeps its own
// copy of the buffer and read position, predicts one response per accepted
// request word and checks every response field in order. Stimulus runs a
// short directed sequence, then random phases over several buffer lengths,
// most with idling on both channels, and ends with a run of reads past the end.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_tb;
   import msbr_pkg::*;

   localparam int CLK_HALF       = 4;
   localparam int LIMIT_CYCLES   = 2000000;
   localparam int LONG_HOLD      = 400;
   localparam int PHASE_WORDS    = 150;
   localparam int PAST_END_READS = 20;
   localparam int TAIL_CYCLES    = 10;
   localparam logic [FUNC_W-1:0] FUNC_TOP = '1;

   typedef struct {
      bit [FUNC_W-1:0]    func;
      bit [CNT_W-1:0]     count;
      bit [POS_W-1:0]     byte_pos;
      bit [BL_W-1:0]      bit_pos;
      bit [BYTE_BITS-1:0] data;
      bit                 fill;
   } reader_word_type;

   typedef struct {
      bit [VAL_W-1:0] value;
      bit             at_end;
      bit [OVR_W-1:0] overrun;
      bit [POS_W-1:0] byte_index;
      bit [BL_W-1:0]  bits_left;
   } reader_result_type;

   typedef struct {
      bit [POS_W-1:0] byte_idx;
      bit [BL_W-1:0]  left;
      bit             done;
      bit [OVR_W-1:0] over;
   } read_pos_type;

   class reader_scoreboard;
      bit [BYTE_BITS-1:0] store [BUF_DEPTH];
      bit                 written [BUF_DEPTH];
      bit [POS_W-1:0]     blen;
      read_pos_type       pos;
      reader_result_type  due_responses [$];
      int                 unwritten_at;
      int                 fails;
      int                 checked;

      function new();
         blen = '0;
         pos.byte_idx = '0;
         pos.left = BL_W'(BYTE_BITS);
         pos.done = 1'b0;
         pos.over = '0;
         unwritten_at = -1;
         fails = 0;
         checked = 0;
      endfunction

      function void set_length(bit [POS_W-1:0] v);
         blen = v;
      endfunction

      function int unsigned eff_len();
         return (blen > BUF_DEPTH) ? BUF_DEPTH : int'(blen);
      endfunction

      function bit [BYTE_BITS-1:0] fetch(bit [ADDR_W-1:0] a);
         if (!written[a] && unwritten_at < 0)
            unwritten_at = int'(a);
         return store[a];
      endfunction

      function void grow_overrun(int unsigned n);
         int unsigned s;
         s = pos.over + n;
         pos.over = (s > COUNT_MAX) ? COUNT_MAX : OVR_W'(s);
      endfunction

      function void check_end();
         int unsigned len;
         len = eff_len();
         if (pos.done || pos.byte_idx >= len) begin
            pos.done = 1'b1;
            pos.byte_idx = POS_W'(len);
            pos.left = BL_W'(BYTE_BITS);
         end
      endfunction

      function void next_byte();
         pos.byte_idx++;
         pos.left = BL_W'(BYTE_BITS);
         if (pos.byte_idx >= eff_len())
            pos.done = 1'b1;
      endfunction

      function bit [VAL_W-1:0] take_bits(int unsigned n);
         bit [63:0]   acc;
         int unsigned b;
         acc = '0;
         if (pos.done) begin
            grow_overrun(n);
            return '0;
         end
         while (n >= pos.left) begin
            b = fetch(ADDR_W'(pos.byte_idx)) & ((1 << pos.left) - 1);
            n -= pos.left;
            acc |= 64'(b) << n;
            next_byte();
            // hitting the end leaves the missing bits as the overrun
            if (pos.done) begin
               pos.over = OVR_W'(n);
               return acc[VAL_W-1:0];
            end
         end
         if (n != 0) begin
            b = fetch(ADDR_W'(pos.byte_idx)) & ((1 << pos.left) - 1);
            acc |= 64'(b >> (pos.left - n));
            pos.left = pos.left - BL_W'(n);
         end
         return acc[VAL_W-1:0];
      endfunction

      function bit [VAL_W-1:0] unpad(bit fill);
         bit [VAL_W-1:0] first;
         if (pos.left == BYTE_BITS || pos.done)
            return VAL_W'(fill);
         first = take_bits(1);
         if (pos.left != BYTE_BITS)
            void'(take_bits(pos.left));
         return first;
      endfunction

      function void set_pos(int unsigned pb, int unsigned pl);
         int unsigned len;
         int unsigned c;
         len = eff_len();
         if (pl < 1 || pl > BYTE_BITS)
            pl = BYTE_BITS;
         if (pb < len) begin
            pos.done = 1'b0;
            pos.byte_idx = POS_W'(pb);
            pos.left = BL_W'(pl);
            pos.over = '0;
         end else begin
            c = (pb - len) * BYTE_BITS + BYTE_BITS - pl;
            pos.done = 1'b1;
            pos.byte_idx = POS_W'(len);
            pos.left = BL_W'(BYTE_BITS);
            pos.over = (c > COUNT_MAX) ? COUNT_MAX : OVR_W'(c);
         end
      endfunction

      function void rewind(int unsigned n);
         int unsigned at;
         // at the end the overrun is given back first
         if (pos.done) begin
            if (n > pos.over) begin
               n -= pos.over;
               pos.over = '0;
            end else begin
               pos.over = pos.over - OVR_W'(n);
               return;
            end
            pos.done = 1'b0;
         end
         at = pos.byte_idx * BYTE_BITS + BYTE_BITS - pos.left;
         at = (n > at) ? 0 : at - n;
         pos.byte_idx = POS_W'(at / BYTE_BITS);
         pos.left = BL_W'(BYTE_BITS - at % BYTE_BITS);
      endfunction

      function int unsigned clamp_read(bit [CNT_W-1:0] n);
         return (n > MAX_READ_BITS) ? MAX_READ_BITS : n;
      endfunction

      // Trial run of a read or unpad: first never-loaded byte it would touch,
      // or -1. The position is restored afterwards.
      function int first_unwritten(reader_word_type w);
         read_pos_type keep;
         keep = pos;
         unwritten_at = -1;
         check_end();
         if (w.func == FUNC_READ)
            void'(take_bits(clamp_read(w.count)));
         else
            void'(unpad(w.fill));
         pos = keep;
         return unwritten_at;
      endfunction

      function void note_word(reader_word_type w);
         reader_result_type r;
         bit [VAL_W-1:0]    v;
         v = '0;
         check_end();
         case (w.func)
            FUNC_LOAD: begin
               if (w.byte_pos < BUF_DEPTH) begin
                  store[w.byte_pos[ADDR_W-1:0]] = w.data;
                  written[w.byte_pos[ADDR_W-1:0]] = 1'b1;
               end
            end
            FUNC_READ:   v = take_bits(clamp_read(w.count));
            FUNC_UNPAD:  v = unpad(w.fill);
            FUNC_SETPOS: set_pos(w.byte_pos, w.bit_pos);
            FUNC_REWIND: rewind(w.count);
            default: ;
         endcase
         r.value = v;
         r.at_end = pos.done;
         r.overrun = pos.over;
         r.byte_index = pos.byte_idx;
         r.bits_left = pos.left;
         due_responses.push_back(r);
      endfunction

      task report(string field, bit [VAL_W-1:0] want, bit [VAL_W-1:0] got);
         // keep the log short on a badly broken build
         if (fails < 100)
            $display("response %0d: %s expected %0h, got %0h", checked, field, want, got);
         fails++;
      endtask

      task check_response(reader_result_type got);
         reader_result_type want;
         checked++;
         if (due_responses.size() == 0) begin
            report("unexpected response, value", '0, got.value);
            return;
         end
         want = due_responses.pop_front();
         if (got.value != want.value)
            report("value", want.value, got.value);
         if (got.at_end != want.at_end)
            report("at_end", want.at_end, got.at_end);
         if (got.overrun != want.overrun)
            report("overrun_bits", want.overrun, got.overrun);
         if (got.byte_index != want.byte_index)
            report("byte_index", want.byte_index, got.byte_index);
         if (got.bits_left != want.bits_left)
            report("bits_left", want.bits_left, got.bits_left);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [CNT_W-1:0]     req_bit_count = '0;
   logic [POS_W-1:0]     req_byte_pos = '0;
   logic [BL_W-1:0]      req_bit_pos = '0;
   logic [BYTE_BITS-1:0] req_load_data = '0;
   logic                 req_fill_bit = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [VAL_W-1:0]     rsp_value;
   logic                 rsp_at_end;
   logic [OVR_W-1:0]     rsp_overrun_bits;
   logic [POS_W-1:0]     rsp_byte_index;
   logic [BL_W-1:0]      rsp_bits_left;
   logic                 csr_wr_en = 1'b0;
   logic [POS_W-1:0]     csr_wr_data = '0;

   reader_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int words_sent = 0;
   int lengths_used = 0;

   msb_first_bit_reader DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_bit_count    (req_bit_count),
      .req_byte_pos     (req_byte_pos),
      .req_bit_pos      (req_bit_pos),
      .req_load_data    (req_load_data),
      .req_fill_bit     (req_fill_bit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_at_end       (rsp_at_end),
      .rsp_overrun_bits (rsp_overrun_bits),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_bits_left    (rsp_bits_left),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   initial begin
      #(2 * CLK_HALF * LIMIT_CYCLES);
      $display("Mismatches found");
      $finish;
   end

   // Receiver: random back-pressure, or a long hold when the stimulus asks.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      reader_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.value = rsp_value;
         got.at_end = rsp_at_end;
         got.overrun = rsp_overrun_bits;
         got.byte_index = rsp_byte_index;
         got.bits_left = rsp_bits_left;
         sb.check_response(got);
      end
   end

   function automatic reader_word_type make_word(bit [FUNC_W-1:0] func, int unsigned count,
                                                 int unsigned byte_pos, int unsigned bit_pos,
                                                 int unsigned data, int unsigned fill);
      reader_word_type w;
      w.func = func;
      w.count = CNT_W'(count);
      w.byte_pos = POS_W'(byte_pos);
      w.bit_pos = BL_W'(bit_pos);
      w.data = BYTE_BITS'(data);
      w.fill = fill[0];
      return w;
   endfunction

   function automatic reader_word_type pick_word();
      reader_word_type w;
      int unsigned     sel;
      int unsigned     len;
      int              hole;
      len = sb.eff_len();
      w = make_word(FUNC_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
      sel = $urandom_range(99);
      if (sel < 18) begin
         sel = $urandom_range(9);
         if (sel < 7)
            w.byte_pos = POS_W'(sb.pos.byte_idx + $urandom_range(6));
         else if (sel < 9 && len != 0)
            w.byte_pos = POS_W'($urandom_range(len - 1));
      end else if (sel < 58) begin
         w.func = FUNC_READ;
         if ($urandom_range(9) != 0)
            w.count = CNT_W'($urandom_range(MAX_READ_BITS));
      end else if (sel < 68) begin
         w.func = FUNC_UNPAD;
      end else if (sel < 81) begin
         w.func = FUNC_SETPOS;
         if ($urandom_range(3) != 0)
            w.byte_pos = POS_W'($urandom_range(len + 1));
         if ($urandom_range(4) != 0)
            w.bit_pos = BL_W'($urandom_range(BYTE_BITS, 1));
      end else if (sel < 96) begin
         w.func = FUNC_REWIND;
         if ($urandom_range(1) != 0)
            w.count = CNT_W'($urandom_range(16));
      end else begin
         w.func = FUNC_W'($urandom_range(FUNC_TOP, FUNC_REWIND + 1));
      end
      // never read a byte that was not loaded: load it instead
      if (w.func == FUNC_READ || w.func == FUNC_UNPAD) begin
         hole = sb.first_unwritten(w);
         if (hole >= 0) begin
            w.func = FUNC_LOAD;
            w.byte_pos = POS_W'(hole);
         end
      end
      return w;
   endfunction

   task automatic send_word(reader_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= w.func;
      req_bit_count <= w.count;
      req_byte_pos <= w.byte_pos;
      req_bit_pos <= w.bit_pos;
      req_load_data <= w.data;
      req_fill_bit <= w.fill;
      do @(posedge clock); while (!req_ready);
      sb.note_word(w);
      words_sent++;
   endtask

   // Hold the sender until every expected response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.due_responses.size() != 0);
   endtask

   task automatic write_length(bit [POS_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_length(v);
      lengths_used++;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin
            send_idle_pct = 36;
            recv_idle_pct <= 59;
         end
         1: begin
            send_idle_pct = 59;
            recv_idle_pct <= 36;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
      endcase
   endtask

   initial begin
      bit [POS_W-1:0] phase_len [12];
      bit [BYTE_BITS-1:0] pattern [6];
      phase_len = '{13'd1, 13'd17, 13'd0, 13'd4096, 13'd3, 13'd64,
                    13'd8191, 13'd9, 13'd300, 13'd2, 13'd4095, 13'd25};
      pattern = '{8'hA5, 8'h00, 8'hFF, 8'h3C, 8'h81, 8'h7E};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: six bytes, then one of each kind and the corner cases
      set_idling(0);
      write_length(13'd6);
      for (int i = 0; i < 6; i++)
         send_word(make_word(FUNC_LOAD, 0, i, 8, pattern[i], 0));
      send_word(make_word(FUNC_LOAD, 0, BUF_DEPTH, 8, 8'h55, 1));   // beyond the store
      send_word(make_word(FUNC_LOAD, 63, 8191, 15, 8'hFF, 1));
      send_word(make_word(FUNC_READ, 0, 0, 8, 0, 0));
      send_word(make_word(FUNC_READ, 1, 0, 8, 0, 0));
      send_word(make_word(FUNC_READ, MAX_READ_BITS, 0, 8, 0, 0));   // spans five bytes
      send_word(make_word(FUNC_UNPAD, 0, 0, 8, 0, 0));
      send_word(make_word(FUNC_UNPAD, 0, 0, 8, 0, 1));              // already aligned
      send_word(make_word(FUNC_READ, 63, 0, 8, 0, 0));             // clamped, runs off the end
      send_word(make_word(FUNC_READ, MAX_READ_BITS, 0, 8, 0, 0));
      send_word(make_word(FUNC_UNPAD, 0, 0, 8, 0, 1));
      send_word(make_word(FUNC_REWIND, 40, 0, 8, 0, 0));           // absorbed by overrun
      send_word(make_word(FUNC_REWIND, 63, 0, 8, 0, 0));
      send_word(make_word(FUNC_SETPOS, 0, 1, 3, 0, 0));
      send_word(make_word(FUNC_REWIND, 5, 0, 8, 0, 0));            // lands on a byte start
      send_word(make_word(FUNC_REWIND, 63, 0, 8, 0, 0));           // before the start
      send_word(make_word(FUNC_SETPOS, 0, 2, 0, 0, 0));
      send_word(make_word(FUNC_SETPOS, 0, 3, 15, 0, 0));
      send_word(make_word(FUNC_SETPOS, 0, 8191, 1, 0, 0));
      send_word(make_word(FUNC_TOP, 63, 8191, 15, 8'hFF, 1));
      send_word(make_word(FUNC_SETPOS, 0, 0, 8, 0, 0));

      for (int p = 0; p < 12; p++) begin
         drain();
         set_idling(p / 4);
         write_length(phase_len[p]);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (p == 1 && i == 40)
               hold_asks <= hold_asks + 1;
            if (p == 6 && i == 75)
               drain();
            send_word(pick_word());
         end
      end

      // grow the overrun count from a far position, then give some back
      drain();
      set_idling(2);
      write_length(13'd0);
      send_word(make_word(FUNC_SETPOS, 0, 8191, 1, 0, 0));
      for (int i = 0; i < PAST_END_READS; i++)
         send_word(make_word(FUNC_READ, MAX_READ_BITS, $urandom, $urandom, $urandom,
                             $urandom));
      send_word(make_word(FUNC_REWIND, 63, 0, 8, 0, 0));
      send_word(make_word(FUNC_READ, 5, 0, 8, 0, 0));
      send_word(make_word(FUNC_SETPOS, 0, 0, 8, 0, 0));

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d request words over %0d buffer lengths, with stalls and reads past the end.",
               words_sent, lengths_used);
      $display("Checked %0d responses, %0d field mismatches.", sb.checked, sb.fails);
      if (sb.fails == 0 && sb.due_responses.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
